>>> hdl/gha_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and state encoding for the generational handle allocator.
package gha_pkg;

  localparam int unsigned CapacityDefault    = 16;
  localparam int unsigned VersionBitsDefault = 8;
  localparam int unsigned QueueDepthDefault  = 32;

  localparam int unsigned InvalidIdentifier  = 0;
  localparam int unsigned StartingIdentifier = 1;

  typedef enum logic [1:0] {
    OP_CREATE      = 2'd0,
    OP_DESTROY     = 2'd1,
    OP_PROCESS     = 2'd2,
    OP_DESTROY_ALL = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_CREATE_ACK  = 3'd0,
    KIND_DESTROY_ACK = 3'd1,
    KIND_CREATED     = 3'd2,
    KIND_DESTROYED   = 3'd3,
    KIND_DONE        = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_PENDING    = 2'd3
  } status_e;

  typedef enum logic {
    CMD_CREATED = 1'b0,
    CMD_DESTROY = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_C_CHK,
    S_C_FIFO,
    S_C_VER,
    S_D_CHK,
    S_D_EV,
    S_P_CHK,
    S_P_EV,
    S_P_DW,
    S_A_CHK,
    S_A_EV
  } state_e;

endpackage

>>> hdl/gha_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with registered read data.
module gha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/generational_handle_allocator.sv
`timescale 1ns / 1ps
// Generational handle allocator: slot table, free list and deferred command queue.
//
// Input channel (in_valid_i / in_stall_o) takes one command per transfer:
// create, destroy, process pending commands, or destroy all. Output channel
// (out_valid_o / out_stall_i) returns result items; the final one of each
// command carries last_o. Create and destroy answer with one ack; process
// gives one event per queued command then done; destroy all adds one
// destroyed event per created slot before done.
// Sequencing: one command is in flight at a time. Create retires each exhausted
// slot at the free list head before reusing a slot, or opens a new one; destroy
// checks the id range and then reads the slot; process reads each queued command
// and, for a destroy, its slot; destroy all then reads every opened slot. Each
// memory step waits on a registered read of the slot table, free list or queue RAM.
// A result sits in a single output register; while the receiver stalls the
// sequencer holds at the next emit, and a new command is accepted once the
// block is back in idle, even with a result still waiting.
// Reset empties the free list and command queue, clears the opened-slot
// count and live count. Slot table entries above the opened count are never
// read, so no clearing pass is needed.
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int unsigned CAPACITY     = gha_pkg::CapacityDefault,
  parameter int unsigned VERSION_BITS = gha_pkg::VersionBitsDefault,
  parameter int unsigned QUEUE_DEPTH  = gha_pkg::QueueDepthDefault,
  localparam int unsigned SlotW = $clog2(CAPACITY),
  localparam int unsigned CntW  = SlotW + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  gha_pkg::opcode_e        opcode_i,
  input  logic [CntW-1:0]         handle_id_i,
  input  logic [VERSION_BITS-1:0] handle_version_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output gha_pkg::kind_e          kind_o,
  output gha_pkg::status_e        status_o,
  output logic [CntW-1:0]         out_id_o,
  output logic [VERSION_BITS-1:0] out_version_o,
  output logic [CntW-1:0]         live_count_o,
  output logic                    last_o
);

  localparam int unsigned VB    = VERSION_BITS;
  localparam int unsigned QW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned SlotDW = VB + 2;          // {version, pending, created}
  localparam int unsigned CmdW  = 1 + SlotW + VB;   // {kind, slot, version}

  // control state
  state_e             state_q, state_d;
  opcode_e            op_q;
  logic [CntW-1:0]    hid_q;
  logic [VB-1:0]      hver_q;
  logic [CntW-1:0]    opened_q;
  logic [SlotW-1:0]   fhead_q;
  logic [CntW-1:0]    fcnt_q;
  logic [QW-1:0]      qhead_q;
  logic [QW:0]        qcnt_q;
  logic [CntW-1:0]    active_q, active_d;
  logic [CntW-1:0]    idx_q;

  // output register
  logic               out_valid_q;
  kind_e              okind_q;
  status_e            ostat_q;
  logic [CntW-1:0]    oid_q;
  logic [VB-1:0]      over_q;
  logic [CntW-1:0]    olive_q;
  logic               olast_q;
  logic               out_free;

  // memory ports
  logic               slot_we, slot_re;
  logic [SlotW-1:0]   slot_waddr, slot_raddr;
  logic [SlotDW-1:0]  slot_wdata, slot_rdata;
  logic               fifo_we, fifo_re;
  logic [SlotW-1:0]   fifo_waddr, fifo_wdata, fifo_rdata;
  logic               cq_we, cq_re;
  logic [QW-1:0]      cq_waddr;
  logic [CmdW-1:0]    cq_wdata, cq_rdata;

  // datapath controls
  logic               emit, e_last;
  kind_e              e_kind;
  status_e            e_status;
  logic [CntW-1:0]    e_id;
  logic [VB-1:0]      e_ver;
  logic               fpop, fpush, qpop, qpush, act_inc, act_dec;
  logic               opened_inc, idx_inc, idx_clr;

  // decoded read data
  logic [VB-1:0]      rd_ver;
  logic               rd_pend, rd_created;
  cmd_e               cq_kind;
  logic [SlotW-1:0]   cq_slot;
  logic [VB-1:0]      cq_ver;
  logic               q_full, bad_id, ver_max;
  logic [CntW-1:0]    dsub;
  logic [SlotW-1:0]   dslot;
  logic [CntW:0]      ftail_sum;
  logic [QW+1:0]      qtail_sum;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign rd_ver     = slot_rdata[SlotDW-1:2];
  assign rd_pend    = slot_rdata[1];
  assign rd_created = slot_rdata[0];
  assign ver_max    = (rd_ver == {VB{1'b1}});
  assign cq_kind    = cmd_e'(cq_rdata[CmdW-1]);
  assign cq_slot    = cq_rdata[CmdW-2:VB];
  assign cq_ver     = cq_rdata[VB-1:0];

  assign q_full = (qcnt_q == (QW+1)'(QUEUE_DEPTH));
  assign dsub   = hid_q - CntW'(StartingIdentifier);
  assign dslot  = dsub[SlotW-1:0];
  assign bad_id = (hid_q == CntW'(InvalidIdentifier)) || (dsub >= opened_q);

  // free list tail, modulo capacity
  assign ftail_sum  = {2'b00, fhead_q} + {1'b0, fcnt_q};
  assign fifo_waddr = (ftail_sum >= (CntW+1)'(CAPACITY)) ?
                      SlotW'(ftail_sum - (CntW+1)'(CAPACITY)) : SlotW'(ftail_sum);
  // command queue tail, modulo depth
  assign qtail_sum  = {2'b00, qhead_q} + {1'b0, qcnt_q};
  assign cq_waddr   = (qtail_sum >= (QW+2)'(QUEUE_DEPTH)) ?
                      QW'(qtail_sum - (QW+2)'(QUEUE_DEPTH)) : QW'(qtail_sum);

  // live count with saturation at both ends
  always_comb begin
    active_d = active_q;
    if (act_inc && active_q < CntW'(CAPACITY)) begin
      active_d = active_q + CntW'(1);
    end else if (act_dec && active_q != '0) begin
      active_d = active_q - CntW'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (opcode_i)
            OP_CREATE:  state_d = S_C_CHK;
            OP_DESTROY: state_d = S_D_CHK;
            default:    state_d = S_P_CHK;
          endcase
        end
      end
      S_C_CHK: begin
        if (!q_full && fcnt_q != '0) begin
          state_d = S_C_FIFO;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_C_FIFO: state_d = S_C_VER;
      S_C_VER: begin
        if (ver_max) begin
          state_d = S_C_CHK;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_D_CHK: begin
        if (!bad_id) begin
          state_d = S_D_EV;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_D_EV: if (out_free) state_d = S_IDLE;
      S_P_CHK: begin
        if (qcnt_q != '0) begin
          state_d = S_P_EV;
        end else if (op_q == OP_DESTROY_ALL) begin
          state_d = S_A_CHK;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_P_EV: begin
        if (cq_kind == CMD_DESTROY) begin
          state_d = S_P_DW;
        end else if (out_free) begin
          state_d = S_P_CHK;
        end
      end
      S_P_DW: if (out_free) state_d = S_P_CHK;
      S_A_CHK: begin
        if (idx_q < opened_q) begin
          state_d = S_A_EV;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_A_EV: begin
        if (!rd_created || out_free) state_d = S_A_CHK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath controls per state
  always_comb begin
    emit       = 1'b0;
    e_kind     = KIND_DONE;
    e_status   = ST_OK;
    e_id       = '0;
    e_ver      = '0;
    e_last     = 1'b0;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_waddr = '0;
    slot_raddr = '0;
    slot_wdata = '0;
    fifo_re    = 1'b0;
    fifo_wdata = '0;
    cq_re      = 1'b0;
    cq_wdata   = '0;
    fpop       = 1'b0;
    fpush      = 1'b0;
    qpop       = 1'b0;
    qpush      = 1'b0;
    act_inc    = 1'b0;
    act_dec    = 1'b0;
    opened_inc = 1'b0;
    idx_inc    = 1'b0;
    idx_clr    = 1'b0;
    unique case (state_q)
      S_IDLE: ;
      S_C_CHK: begin
        if (q_full) begin
          if (out_free) begin
            emit     = 1'b1;
            e_kind   = KIND_CREATE_ACK;
            e_status = ST_FULL;
            e_last   = 1'b1;
          end
        end else if (fcnt_q != '0) begin
          fifo_re = 1'b1;
        end else if (opened_q < CntW'(CAPACITY)) begin
          if (out_free) begin
            slot_we    = 1'b1;
            slot_waddr = opened_q[SlotW-1:0];
            slot_wdata = {{VB{1'b0}}, 1'b0, 1'b1};
            qpush      = 1'b1;
            cq_wdata   = {CMD_CREATED, opened_q[SlotW-1:0], {VB{1'b0}}};
            opened_inc = 1'b1;
            emit       = 1'b1;
            e_kind     = KIND_CREATE_ACK;
            e_id       = opened_q + CntW'(StartingIdentifier);
            e_last     = 1'b1;
          end
        end else if (out_free) begin
          emit     = 1'b1;
          e_kind   = KIND_CREATE_ACK;
          e_status = ST_FULL;
          e_last   = 1'b1;
        end
      end
      S_C_FIFO: begin
        slot_re    = 1'b1;
        slot_raddr = fifo_rdata;
      end
      S_C_VER: begin
        if (ver_max) begin
          fpop = 1'b1;                  // retire exhausted slot
        end else if (out_free) begin
          fpop       = 1'b1;
          slot_we    = 1'b1;
          slot_waddr = fifo_rdata;
          slot_wdata = {rd_ver, rd_pend, 1'b1};
          qpush      = 1'b1;
          cq_wdata   = {CMD_CREATED, fifo_rdata, rd_ver};
          emit       = 1'b1;
          e_kind     = KIND_CREATE_ACK;
          e_id       = {1'b0, fifo_rdata} + CntW'(StartingIdentifier);
          e_ver      = rd_ver;
          e_last     = 1'b1;
        end
      end
      S_D_CHK: begin
        if (!bad_id) begin
          slot_re    = 1'b1;
          slot_raddr = dslot;
        end else if (out_free) begin
          emit     = 1'b1;
          e_kind   = KIND_DESTROY_ACK;
          e_status = ST_BAD_HANDLE;
          e_id     = hid_q;
          e_ver    = hver_q;
          e_last   = 1'b1;
        end
      end
      S_D_EV: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_DESTROY_ACK;
          e_id   = hid_q;
          e_ver  = hver_q;
          e_last = 1'b1;
          priority if (!rd_created || rd_ver != hver_q) begin
            e_status = ST_BAD_HANDLE;
          end else if (rd_pend) begin
            e_status = ST_PENDING;
          end else if (q_full) begin
            e_status = ST_FULL;
          end else begin
            e_status   = ST_OK;
            slot_we    = 1'b1;
            slot_waddr = dslot;
            slot_wdata = {rd_ver, 1'b1, 1'b1};
            qpush      = 1'b1;
            cq_wdata   = {CMD_DESTROY, dslot, rd_ver};
          end
        end
      end
      S_P_CHK: begin
        if (qcnt_q != '0) begin
          cq_re = 1'b1;
        end else if (op_q == OP_DESTROY_ALL) begin
          idx_clr = 1'b1;
        end else if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_DONE;
          e_last = 1'b1;
        end
      end
      S_P_EV: begin
        if (cq_kind == CMD_DESTROY) begin
          slot_re    = 1'b1;
          slot_raddr = cq_slot;
        end else if (out_free) begin
          act_inc = 1'b1;
          qpop    = 1'b1;
          emit    = 1'b1;
          e_kind  = KIND_CREATED;
          e_id    = {1'b0, cq_slot} + CntW'(StartingIdentifier);
          e_ver   = cq_ver;
        end
      end
      S_P_DW: begin
        if (out_free) begin
          act_dec    = 1'b1;
          qpop       = 1'b1;
          emit       = 1'b1;
          e_kind     = KIND_DESTROYED;
          e_id       = {1'b0, cq_slot} + CntW'(StartingIdentifier);
          e_ver      = cq_ver;
          slot_we    = 1'b1;
          slot_waddr = cq_slot;
          slot_wdata = {rd_ver + VB'(1), 1'b0, 1'b0};
          fpush      = (fcnt_q < CntW'(CAPACITY));
          fifo_wdata = cq_slot;
        end
      end
      S_A_CHK: begin
        if (idx_q < opened_q) begin
          slot_re    = 1'b1;
          slot_raddr = idx_q[SlotW-1:0];
        end else if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_DONE;
          e_last = 1'b1;
        end
      end
      S_A_EV: begin
        if (!rd_created) begin
          idx_inc = 1'b1;
        end else if (out_free) begin
          idx_inc    = 1'b1;
          act_dec    = 1'b1;
          emit       = 1'b1;
          e_kind     = KIND_DESTROYED;
          e_id       = idx_q + CntW'(StartingIdentifier);
          e_ver      = rd_ver;
          slot_we    = 1'b1;
          slot_waddr = idx_q[SlotW-1:0];
          slot_wdata = {rd_ver + VB'(1), 1'b0, 1'b0};
          fpush      = (fcnt_q < CntW'(CAPACITY));
          fifo_wdata = idx_q[SlotW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign fifo_we = fpush;
  assign cq_we   = qpush;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      opened_q    <= '0;
      fhead_q     <= '0;
      fcnt_q      <= '0;
      qhead_q     <= '0;
      qcnt_q      <= '0;
      active_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      if (opened_inc) opened_q <= opened_q + CntW'(1);
      if (fpop) begin
        fhead_q <= (fhead_q == SlotW'(CAPACITY - 1)) ? '0 : fhead_q + SlotW'(1);
        fcnt_q  <= fcnt_q - CntW'(1);
      end else if (fpush) begin
        fcnt_q  <= fcnt_q + CntW'(1);
      end
      if (qpop) begin
        qhead_q <= (qhead_q == QW'(QUEUE_DEPTH - 1)) ? '0 : qhead_q + QW'(1);
        qcnt_q  <= qcnt_q - (QW+1)'(1);
      end else if (qpush) begin
        qcnt_q  <= qcnt_q + (QW+1)'(1);
      end
      if (idx_clr) begin
        idx_q <= '0;
      end else if (idx_inc) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q   <= opcode_i;
      hid_q  <= handle_id_i;
      hver_q <= handle_version_i;
    end
    if (emit) begin
      okind_q <= e_kind;
      ostat_q <= e_status;
      oid_q   <= e_id;
      over_q  <= e_ver;
      olive_q <= active_d;
      olast_q <= e_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = okind_q;
  assign status_o      = ostat_q;
  assign out_id_o      = oid_q;
  assign out_version_o = over_q;
  assign live_count_o  = olive_q;
  assign last_o        = olast_q;

  gha_ram #(.Width(SlotDW), .Depth(CAPACITY)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  gha_ram #(.Width(SlotW), .Depth(CAPACITY)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .re_i    (fifo_re),
    .raddr_i (fhead_q),
    .rdata_o (fifo_rdata)
  );

  gha_ram #(.Width(CmdW), .Depth(QUEUE_DEPTH)) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (cq_we),
    .waddr_i (cq_waddr),
    .wdata_i (cq_wdata),
    .re_i    (cq_re),
    .raddr_i (qhead_q),
    .rdata_o (cq_rdata)
  );

endmodule

>>> hdl/gha_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the generational handle allocator, bound to the top level.
module gha_checker
  import gha_pkg::*;
#(
  parameter int unsigned CAPACITY     = gha_pkg::CapacityDefault,
  parameter int unsigned VERSION_BITS = gha_pkg::VersionBitsDefault,
  parameter int unsigned QUEUE_DEPTH  = gha_pkg::QueueDepthDefault,
  localparam int unsigned CntW = $clog2(CAPACITY) + 1
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input gha_pkg::opcode_e        opcode_i,
  input logic [CntW-1:0]         handle_id_i,
  input logic [VERSION_BITS-1:0] handle_version_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input gha_pkg::kind_e          kind_o,
  input gha_pkg::status_e        status_o,
  input logic [CntW-1:0]         out_id_o,
  input logic [VERSION_BITS-1:0] out_version_o,
  input logic [CntW-1:0]         live_count_o,
  input logic                    last_o
);

  // a held result keeps its content
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(out_id_o))
    else $error("stalled result changed");

  // one command in flight: busy right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command taken while busy");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_CREATE_ACK || kind_o == KIND_DESTROY_ACK ||
                    kind_o == KIND_DONE) |-> last_o)
    else $error("ack or done without last");

  a_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_CREATED || kind_o == KIND_DESTROYED)
      |-> !last_o && status_o == ST_OK)
    else $error("event marked last or with status");

  a_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> live_count_o <= CntW'(CAPACITY))
    else $error("live count above capacity");

endmodule

bind generational_handle_allocator gha_checker #(
  .CAPACITY     (CAPACITY),
  .VERSION_BITS (VERSION_BITS),
  .QUEUE_DEPTH  (QUEUE_DEPTH)
) u_gha_checker (.*);

>>> test/gha_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the generational handle allocator: tracks the handle table and checks results.
module gha_result_checker
  import gha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  opcode_e          opcode_i,
  input  logic [4:0]       handle_id_i,
  input  logic [7:0]       handle_version_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  kind_e            kind_i,
  input  status_e          status_i,
  input  logic [4:0]       out_id_i,
  input  logic [7:0]       out_version_i,
  input  logic [4:0]       live_count_i,
  input  logic             last_i,
  output int               mismatch_cnt_o,
  output int               waiting_cnt_o
);

  localparam int Slots    = 16;
  localparam int CmdDepth = 32;
  localparam logic [7:0] VerMax = 8'hFF;

  typedef struct packed {
    kind_e      kind;
    status_e    status;
    logic [4:0] id;
    logic [7:0] ver;
    logic [4:0] live;
    logic       last;
  } result_t;

  result_t    expected_results[$];

  logic [7:0] slot_ver[Slots];
  logic       slot_created[Slots];
  logic       slot_pending[Slots];
  int         opened;
  int         free_list[Slots];
  int         free_head, free_cnt;
  cmd_e       cmd_kind[CmdDepth];
  int         cmd_slot[CmdDepth];
  logic [7:0] cmd_ver[CmdDepth];
  int         cmd_head, cmd_cnt;
  int         live;

  task automatic post(kind_e k, status_e st, int id, logic [7:0] ver);
    result_t r;
    r.kind = k; r.status = st; r.id = id[4:0]; r.ver = ver;
    r.live = live[4:0]; r.last = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic release_slot(int s);
    slot_ver[s] = slot_ver[s] + 8'd1;
    slot_created[s] = 1'b0;
    slot_pending[s] = 1'b0;
    if (free_cnt < Slots) begin
      free_list[(free_head + free_cnt) % Slots] = s;
      free_cnt++;
    end
  endtask

  task automatic retire_slot(int s, logic [7:0] ver);
    if (live > 0) live--;
    post(KIND_DESTROYED, ST_OK, s + StartingIdentifier, ver);
    release_slot(s);
  endtask

  task automatic drain_commands();
    while (cmd_cnt > 0) begin
      if (cmd_kind[cmd_head] == CMD_CREATED) begin
        if (live < Slots) live++;
        post(KIND_CREATED, ST_OK, cmd_slot[cmd_head] + StartingIdentifier, cmd_ver[cmd_head]);
      end else begin
        retire_slot(cmd_slot[cmd_head], cmd_ver[cmd_head]);
      end
      cmd_head = (cmd_head + 1) % CmdDepth;
      cmd_cnt--;
    end
  endtask

  task automatic queue_cmd(cmd_e k, int s);
    int i;
    i = (cmd_head + cmd_cnt) % CmdDepth;
    cmd_kind[i] = k;
    cmd_slot[i] = s;
    cmd_ver[i]  = slot_ver[s];
    cmd_cnt++;
  endtask

  // Expected results of one accepted command, in order.
  task automatic predict_command(opcode_e op, logic [4:0] id, logic [7:0] ver);
    int s;
    status_e st;
    s = 0;
    case (op)
      OP_CREATE: begin
        if (cmd_cnt >= CmdDepth) begin
          post(KIND_CREATE_ACK, ST_FULL, InvalidIdentifier, 8'd0);
        end else begin
          // exhausted slots drop out of the free list for good
          while (free_cnt > 0 && slot_ver[free_list[free_head]] == VerMax) begin
            free_head = (free_head + 1) % Slots;
            free_cnt--;
          end
          if (free_cnt > 0) begin
            s = free_list[free_head];
            free_head = (free_head + 1) % Slots;
            free_cnt--;
          end else if (opened < Slots) begin
            s = opened;
            opened++;
          end else begin
            s = -1;
          end
          if (s < 0) begin
            post(KIND_CREATE_ACK, ST_FULL, InvalidIdentifier, 8'd0);
          end else begin
            slot_created[s] = 1'b1;
            queue_cmd(CMD_CREATED, s);
            post(KIND_CREATE_ACK, ST_OK, s + StartingIdentifier, slot_ver[s]);
          end
        end
      end
      OP_DESTROY: begin
        if (id == InvalidIdentifier || int'(id) - 1 >= opened) begin
          st = ST_BAD_HANDLE;
        end else begin
          s = int'(id) - 1;
          if (!slot_created[s] || slot_ver[s] != ver) st = ST_BAD_HANDLE;
          else if (slot_pending[s]) st = ST_PENDING;
          else if (cmd_cnt >= CmdDepth) st = ST_FULL;
          else begin
            slot_pending[s] = 1'b1;
            queue_cmd(CMD_DESTROY, s);
            st = ST_OK;
          end
        end
        post(KIND_DESTROY_ACK, st, id, ver);
      end
      default: begin
        drain_commands();
        if (op == OP_DESTROY_ALL) begin
          for (int k = 0; k < opened; k++) begin
            if (slot_created[k]) retire_slot(k, slot_ver[k]);
          end
        end
        post(KIND_DONE, ST_OK, InvalidIdentifier, 8'd0);
      end
    endcase
    expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r, got_r;
    if (!rst_ni) begin
      expected_results.delete();
      for (int k = 0; k < Slots; k++) begin
        slot_ver[k] = 8'd0; slot_created[k] = 1'b0; slot_pending[k] = 1'b0;
        free_list[k] = 0;
      end
      opened = 0; free_head = 0; free_cnt = 0;
      cmd_head = 0; cmd_cnt = 0; live = 0;
      mismatch_cnt_o = 0;
    end else begin
      // results first: a transfer on this edge can't belong to a command taken now
      if (out_valid_i && !out_stall_i) begin
        got_r = {kind_i, status_i, out_id_i, out_version_i, live_count_i, last_i};
        if (expected_results.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("unexpected result: kind %0d status %0d id %0d ver %0d live %0d last %0d",
                     got_r.kind, got_r.status, got_r.id, got_r.ver, got_r.live, got_r.last);
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r !== exp_r) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10)
              $display("mismatch: exp kind %0d st %0d id %0d ver %0d live %0d last %0d / got kind %0d st %0d id %0d ver %0d live %0d last %0d",
                       exp_r.kind, exp_r.status, exp_r.id, exp_r.ver, exp_r.live, exp_r.last,
                       got_r.kind, got_r.status, got_r.id, got_r.ver, got_r.live, got_r.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_command(opcode_i, handle_id_i, handle_version_i);
    end
    waiting_cnt_o = expected_results.size();
  end

endmodule

>>> test/tb_generational_handle_allocator.sv
`timescale 1ns / 1ps
// Testbench top for the generational handle allocator: clock, reset, stimulus and verdict.
module tb_generational_handle_allocator;
  import gha_pkg::*;

  localparam int CycleLimit = 1500000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  opcode_e    opcode = OP_PROCESS;
  logic [4:0] handle_id = '0;
  logic [7:0] handle_version = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  kind_e      kind;
  status_e    status;
  logic [4:0] out_id;
  logic [7:0] out_version;
  logic [4:0] live_count;
  logic       last;
  int         mismatch_cnt, waiting_cnt;

  // issued handles seen on create acks, used for mostly valid destroys
  logic [12:0] handles[$];
  bit          quiet = 1'b0;     // no gaps, no stalls
  int          stall_hold = 0;
  int          cycle_cnt = 0;

  always #4 clk_i = ~clk_i;

  generational_handle_allocator dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .handle_id_i(handle_id), .handle_version_i(handle_version),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .status_o(status), .out_id_o(out_id), .out_version_o(out_version),
    .live_count_o(live_count), .last_o(last)
  );

  gha_result_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .handle_id_i(handle_id), .handle_version_i(handle_version),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .kind_i(kind), .status_i(status), .out_id_i(out_id), .out_version_i(out_version),
    .live_count_i(live_count), .last_i(last),
    .mismatch_cnt_o(mismatch_cnt), .waiting_cnt_o(waiting_cnt)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver side: stall for random stretches, mostly short
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= !quiet && ($urandom_range(0, 2) == 0);
      stall_hold <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    if (out_valid && !out_stall && kind == KIND_CREATE_ACK && status == ST_OK) begin
      handles.push_back({out_id, out_version});
      if (handles.size() > 32) void'(handles.pop_front());
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one transfer; returns at the edge that took it, or after a random gap following it
  task automatic send(opcode_e op, logic [4:0] id, logic [7:0] ver);
    int g;
    in_valid <= 1'b1;
    opcode <= op;
    handle_id <= id;
    handle_version <= ver;
    do @(posedge clk_i); while (in_stall);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_destroy_random();
    logic [12:0] h;
    if (handles.size() > 0 && $urandom_range(0, 9) != 0) begin
      h = handles[$urandom_range(0, handles.size() - 1)];
      send(OP_DESTROY, h[12:8], h[7:0]);
    end else begin
      send(OP_DESTROY, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (waiting_cnt != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bad handles on an empty table, empty process and destroy all
    send(OP_DESTROY, 5'd0, 8'd0);
    send(OP_DESTROY, 5'd16, 8'd0);
    send(OP_PROCESS, 5'd0, 8'd0);
    send(OP_DESTROY_ALL, 5'd0, 8'd0);
    send(OP_CREATE, 5'd0, 8'd0);
    send(OP_CREATE, 5'd0, 8'd0);
    send(OP_CREATE, 5'd0, 8'd0);
    send(OP_DESTROY, 5'd1, 8'd0);
    send(OP_DESTROY, 5'd1, 8'd0);     // repeated destroy
    send(OP_DESTROY, 5'd2, 8'd255);   // stale version
    send(OP_DESTROY, 5'd31, 8'hAA);   // beyond opened slots
    send(OP_DESTROY, 5'd4, 8'd0);     // never opened
    send(OP_PROCESS, 5'd0, 8'd0);
    send(OP_DESTROY, 5'd1, 8'd0);     // destroyed already
    send(OP_CREATE, 5'd0, 8'd0);      // reuses handle id 1 (slot 0), version 1
    send(OP_DESTROY_ALL, 5'd0, 8'd0);
    // table full: 17 creates, then destroy all with pending commands
    repeat (17) send(OP_CREATE, 5'd0, 8'd0);
    send(OP_DESTROY_ALL, 5'd0, 8'd0);

    // random, mostly well formed
    for (int n = 0; n < 65; n++) begin
      quiet = (n >= 25 && n < 40);
      if (n == 45) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 38) send(OP_CREATE, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
      else if (r < 72) send_destroy_random();
      else if (r < 94) send(OP_PROCESS, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
      else send(OP_DESTROY_ALL, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    @(negedge clk_i);
    while (waiting_cnt != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_cnt == 0 && waiting_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> generational_handle_allocator.f
hdl/gha_pkg.sv
hdl/gha_ram.sv
hdl/generational_handle_allocator.sv
hdl/gha_checker.sv
test/gha_result_checker.sv
test/tb_generational_handle_allocator.sv
